// File: rtl/tsm_pkg.sv
package tsm_pkg;

  // Widths of the item fields.
  localparam int unsigned RuleW  = 8;
  localparam int unsigned IndexW = 3;
  localparam int unsigned ValueW = 16;
  localparam int unsigned ColorW = 8;

  // Rule codes.
  localparam logic [RuleW-1:0] DayOff     = 8'd0;
  localparam logic [RuleW-1:0] DayWeekday = 8'd8;
  localparam logic [RuleW-1:0] DayWeekend = 8'd9;
  localparam logic [RuleW-1:0] DayEvery   = 8'd10;
  localparam logic [RuleW-1:0] UnitEvery  = 8'd100;

  // Day ranges for the weekday and weekend rules.
  localparam logic [RuleW-1:0] WeekdayFirst = 8'd1;
  localparam logic [RuleW-1:0] WeekdayLast  = 8'd5;
  localparam logic [RuleW-1:0] WeekendFirst = 8'd6;
  localparam logic [RuleW-1:0] WeekendLast  = 8'd7;

  // Request types.
  localparam logic ReqWrite = 1'b0;
  localparam logic ReqCheck = 1'b1;

  // Remainder unit: bits retired per cycle and cycles per operation.
  localparam int unsigned DivBitsPerCycle = 2;
  localparam int unsigned DivCycles       = RuleW / DivBitsPerCycle;
  localparam int unsigned DivCntW         = $clog2(DivCycles);

  typedef struct packed {
    logic [RuleW-1:0]  day_rule;
    logic [RuleW-1:0]  hour_rule;
    logic [RuleW-1:0]  minute_rule;
    logic [RuleW-1:0]  action;
    logic [ValueW-1:0] value;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } entry_t;

  typedef struct packed {
    logic [IndexW-1:0] index;
    logic [RuleW-1:0]  action;
    logic [ValueW-1:0] value;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [RuleW-1:0] dividend;
    logic [RuleW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } div_rsp_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_START = 6'b000100,
    S_WAIT  = 6'b001000,
    S_PUSH  = 6'b010000,
    S_FLUSH = 6'b100000
  } state_e;

endpackage

// File: rtl/tsm_table.sv
module tsm_table
  import tsm_pkg::*;
#(
  parameter int unsigned ENTRY_COUNT = 8,
  parameter int unsigned IDX_W       = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  entry_t           wr_data_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output entry_t           rd_data_o
);

  entry_t                 mem_q [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] written_q;
  entry_t                 rd_data_q;
  logic                   rd_written_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Entries never written read as all zero, which is an entry that is off.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_written_q ? rd_data_q : '0;

endmodule

// File: rtl/tsm_divcheck.sv
module tsm_divcheck
  import tsm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [RuleW-1:0]   rem_q, rem_d;
  logic [RuleW-1:0]   dvd_q, dvd_d;
  logic [RuleW-1:0]   div_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;

  // Restoring remainder, DivBitsPerCycle dividend bits per cycle.
  always_comb begin
    logic [RuleW:0] trial;
    rem_d = rem_q;
    dvd_d = dvd_q;
    for (int k = 0; k < DivBitsPerCycle; k++) begin
      trial = {rem_d, dvd_d[RuleW-1]};
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      rem_d = trial[RuleW-1:0];
      dvd_d = {dvd_d[RuleW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= req_i.dividend;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(DivCycles - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.zero = (rem_q == '0);

endmodule

// File: rtl/timer_schedule_matcher_core.sv
// Schedule matcher. A table of ENTRY_COUNT schedule entries sits in a
// synchronous memory; a write transaction (req_type 0) stores one entry, and
// indexes at or beyond ENTRY_COUNT are dropped. A time
// transaction (req_type 1) is dropped while enable is low, or when its hour
// and minute (low 5 and 6 bits) equal those of the last time that was
// checked; otherwise the block walks the table in index order and sends one
// result transaction per matching entry, with last_match set on the final
// one. A check with no match sends nothing. Each entry goes through the same
// steps in order: a memory read, a launch of the three remainder units that
// test the every-Nth day, hour and minute rules in parallel, a wait while
// those units retire two bits per cycle, and a check that they have finished.
// Each match after the first adds a step that moves the previous match on,
// and that step waits while the output register holds a result not yet taken.
// The closing step hands the last match on and likewise waits for the output;
// the input accepts nothing until the walk ends. Results pass through a
// one-entry holding register so that the last marker can be set, then an
// output register that the sink drains at its own pace. The enable register
// has its own write channel, which is always ready.
module timer_schedule_matcher_core
  import tsm_pkg::*;
#(
  parameter int unsigned ENTRY_COUNT = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_enable_i,

  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic [IndexW-1:0] entry_index_i,
  input  logic [RuleW-1:0]  day_i,
  input  logic [RuleW-1:0]  hour_i,
  input  logic [RuleW-1:0]  minute_i,
  input  logic [RuleW-1:0]  action_i,
  input  logic [ValueW-1:0] action_value_i,
  input  logic [ColorW-1:0] red_i,
  input  logic [ColorW-1:0] green_i,
  input  logic [ColorW-1:0] blue_i,

  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IndexW-1:0] match_index_o,
  output logic [RuleW-1:0]  fired_action_o,
  output logic [ValueW-1:0] fired_value_o,
  output logic [ColorW-1:0] fired_red_o,
  output logic [ColorW-1:0] fired_green_o,
  output logic [ColorW-1:0] fired_blue_o,
  output logic              last_match_o
);

  localparam int unsigned IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

  state_e state_q, state_d;
  state_e state_next;

  logic [IDX_W-1:0] idx_q, idx_d, idx_inc;
  logic             enable_q;
  logic [4:0]       prev_hour_q;
  logic [5:0]       prev_minute_q;
  logic             prev_valid_q;
  logic [RuleW-1:0] cur_day_q, cur_hour_q, cur_minute_q;

  result_t pend_q, out_q, hit_result;
  logic    pend_valid_q;
  logic    out_valid_q, out_last_q;

  logic in_fire, time_go, repeated, out_free;
  logic pend_load, pend_clr, out_load, out_last;
  logic rd_en, div_start, div_done, entry_hit;
  logic day_hit, hour_hit, minute_hit;

  entry_t   wr_entry, rd_entry;
  logic     wr_en;
  div_req_t day_req, hour_req, minute_req;
  div_rsp_t day_rsp, hour_rsp, minute_rsp;

  // Configuration channel.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_valid_i) begin
      enable_q <= cfg_enable_i;
    end
  end

  // Input side: one transaction at a time, taken only while the walk is idle.
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign repeated   = prev_valid_q && (prev_hour_q == hour_i[4:0]) &&
                      (prev_minute_q == minute_i[5:0]);
  assign time_go    = in_fire && (req_type_i == ReqCheck) && enable_q && !repeated;

  assign wr_en = in_fire && (req_type_i == ReqWrite) &&
                 (ENTRY_COUNT > int'(entry_index_i));

  always_comb begin
    wr_entry.day_rule    = day_i;
    wr_entry.hour_rule   = hour_i;
    wr_entry.minute_rule = minute_i;
    wr_entry.action      = action_i;
    wr_entry.value       = action_value_i;
    wr_entry.red         = red_i;
    wr_entry.green       = green_i;
    wr_entry.blue        = blue_i;
  end

  tsm_table #(
    .ENTRY_COUNT (ENTRY_COUNT),
    .IDX_W       (IDX_W)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (IDX_W'(entry_index_i)),
    .wr_data_i (wr_entry),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_entry)
  );

  // The current time is latched at acceptance, and the previous-time store is
  // updated right away since nothing else reads it during the walk.
  always_ff @(posedge clk_i) begin
    if (time_go) begin
      cur_day_q    <= day_i;
      cur_hour_q   <= hour_i;
      cur_minute_q <= minute_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_hour_q   <= '0;
      prev_minute_q <= '0;
      prev_valid_q  <= 1'b0;
    end else if (time_go) begin
      prev_hour_q   <= hour_i[4:0];
      prev_minute_q <= minute_i[5:0];
      prev_valid_q  <= 1'b1;
    end
  end

  // Three remainder units test the every-Nth rules of one entry in parallel.
  // Their divisors are only meaningful when the rule is above its threshold.
  always_comb begin
    day_req.start       = div_start;
    day_req.dividend    = cur_day_q;
    day_req.divisor     = rd_entry.day_rule - DayEvery;
    hour_req.start      = div_start;
    hour_req.dividend   = cur_hour_q;
    hour_req.divisor    = rd_entry.hour_rule - UnitEvery;
    minute_req.start    = div_start;
    minute_req.dividend = cur_minute_q;
    minute_req.divisor  = rd_entry.minute_rule - UnitEvery;
  end

  tsm_divcheck u_day_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (day_req),
    .rsp_o  (day_rsp)
  );

  tsm_divcheck u_hour_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hour_req),
    .rsp_o  (hour_rsp)
  );

  tsm_divcheck u_minute_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (minute_req),
    .rsp_o  (minute_rsp)
  );

  assign div_done = day_rsp.done && hour_rsp.done && minute_rsp.done;

  // Rule evaluation on the entry held at the memory output.
  always_comb begin
    day_hit = 1'b0;
    if (rd_entry.day_rule != DayOff) begin
      if (rd_entry.day_rule == DayEvery || rd_entry.day_rule == cur_day_q) begin
        day_hit = 1'b1;
      end else if (rd_entry.day_rule == DayWeekday) begin
        day_hit = cur_day_q inside {[WeekdayFirst:WeekdayLast]};
      end else if (rd_entry.day_rule == DayWeekend) begin
        day_hit = cur_day_q inside {[WeekendFirst:WeekendLast]};
      end else if (rd_entry.day_rule > DayEvery) begin
        day_hit = day_rsp.zero;
      end
    end
    hour_hit   = (rd_entry.hour_rule == cur_hour_q) ||
                 ((rd_entry.hour_rule > UnitEvery) && hour_rsp.zero);
    minute_hit = (rd_entry.minute_rule == cur_minute_q) ||
                 ((rd_entry.minute_rule > UnitEvery) && minute_rsp.zero);
    entry_hit  = day_hit && hour_hit && minute_hit;
  end

  always_comb begin
    hit_result.index  = IndexW'(idx_q);
    hit_result.action = rd_entry.action;
    hit_result.value  = rd_entry.value;
    hit_result.red    = rd_entry.red;
    hit_result.green  = rd_entry.green;
    hit_result.blue   = rd_entry.blue;
  end

  // Walk control. A match waits in the holding register until either a
  // later match pushes it out as not-last, or the walk ends and it leaves
  // marked as last.
  assign out_free   = !out_valid_q || out_ready_i;
  assign idx_inc    = idx_q + IDX_W'(1);
  assign state_next = (idx_q == LAST_IDX) ? S_FLUSH : S_READ;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    rd_en     = 1'b0;
    div_start = 1'b0;
    pend_load = 1'b0;
    pend_clr  = 1'b0;
    out_load  = 1'b0;
    out_last  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (time_go) begin
          idx_d   = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        rd_en   = 1'b1;
        state_d = S_START;
      end
      S_START: begin
        div_start = 1'b1;
        state_d   = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          if (entry_hit && pend_valid_q) begin
            state_d = S_PUSH;
          end else begin
            pend_load = entry_hit;
            idx_d     = idx_inc;
            state_d   = state_next;
          end
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_load  = 1'b1;
          pend_load = 1'b1;
          idx_d     = idx_inc;
          state_d   = state_next;
        end
      end
      S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_load = 1'b1;
          out_last = 1'b1;
          pend_clr = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (pend_load) begin
        pend_valid_q <= 1'b1;
      end else if (pend_clr) begin
        pend_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_load) begin
      pend_q <= hit_result;
    end
    if (out_load) begin
      out_q      <= pend_q;
      out_last_q <= out_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign match_index_o  = out_q.index;
  assign fired_action_o = out_q.action;
  assign fired_value_o  = out_q.value;
  assign fired_red_o    = out_q.red;
  assign fired_green_o  = out_q.green;
  assign fired_blue_o   = out_q.blue;
  assign last_match_o   = out_last_q;

endmodule
